// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL. Each macro assumes a clock named clk and
// an active-high reset named rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/spr_seq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spr_seq_pkg;

  // Depth of the frame table.
  localparam int MAX_FRAMES = 16;

  // Request codes.
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_START   = 3'd1;
  localparam logic [2:0] REQ_PAUSE   = 3'd2;
  localparam logic [2:0] REQ_UNPAUSE = 3'd3;
  localparam logic [2:0] REQ_STOP    = 3'd4;
  localparam logic [2:0] REQ_LOAD    = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [0:0] REG_FRAME_COUNT = 1'b0;
  localparam logic [0:0] REG_REPEAT_MODE = 1'b1;

  typedef struct packed {
    logic       flip_y;
    logic       flip_x;
    logic [7:0] frame_id;
    logic [15:0] duration;
  } entry_t;

  typedef struct packed {
    logic [4:0] frame_count;
    logic       repeat_mode;
  } cfg_t;

  typedef struct packed {
    logic   we;
    logic [3:0] addr;
    entry_t data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spr_seq_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface spr_seq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] time_step;
  logic [3:0]  entry_index;
  logic [15:0] entry_duration;
  logic [7:0]  entry_frame_id;
  logic        entry_flip_x;
  logic        entry_flip_y;

  modport source (
    output valid, req_type, time_step, entry_index, entry_duration,
           entry_frame_id, entry_flip_x, entry_flip_y,
    input  ready
  );

  modport sink (
    input  valid, req_type, time_step, entry_index, entry_duration,
           entry_frame_id, entry_flip_x, entry_flip_y,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/spr_seq_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface spr_seq_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] frame_position;
  logic [7:0] frame_id;
  logic       flip_x;
  logic       flip_y;
  logic       is_running;
  logic       is_paused;

  modport source (
    output valid, frame_position, frame_id, flip_x, flip_y, is_running, is_paused,
    input  ready
  );

  modport sink (
    input  valid, frame_position, frame_id, flip_x, flip_y, is_running, is_paused,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/spr_seq_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spr_seq_regs import spr_seq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [4:0] frame_count;
  logic       repeat_mode;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= 5'd0;
      repeat_mode <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[2:2])
        REG_FRAME_COUNT: frame_count <= pwdata[4:0];
        REG_REPEAT_MODE: repeat_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      REG_FRAME_COUNT: prdata = {27'd0, frame_count};
      REG_REPEAT_MODE: prdata = {31'd0, repeat_mode};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg.frame_count = frame_count;
  assign cfg.repeat_mode = repeat_mode;

endmodule

`default_nettype wire

// ===== hw/rtl/spr_seq_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spr_seq_mem import spr_seq_pkg::*; (
  input  wire logic       clk,
  input  wire mem_wr_t    wr,
  input  wire logic [3:0] raddr,
  output entry_t          rdata
);

  entry_t mem [MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spr_seq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spr_seq_ctrl import spr_seq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  spr_seq_req_if.sink   req,
  spr_seq_rsp_if.source rsp,
  output mem_wr_t     mem_wr,
  output logic [3:0]  cur_idx,
  input  wire entry_t rd_entry
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]  state;
  logic        running;
  logic        paused;
  logic        tick_act;
  logic [16:0] elapsed;
  logic        out_valid;

  logic        in_fire;
  logic [4:0]  eff_cnt;
  logic [15:0] dur;
  logic        gt;
  logic [16:0] diff;
  logic [4:0]  idx_inc;
  logic        at_end;
  logic [15:0] load_dur;
  logic        tick_go;
  logic        resp_load;

  assign in_fire   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  // A frame count beyond the table depth acts as the depth.
  assign eff_cnt = (cfg.frame_count > 5'(MAX_FRAMES)) ? 5'(MAX_FRAMES) : cfg.frame_count;

  // A tick only does work while running, not paused and with more than one frame.
  assign tick_go = (req.req_type == REQ_TICK) && running && !paused && (eff_cnt > 5'd1);

  // Shared compare and subtract against the current frame's duration.
  assign dur     = (rd_entry.duration == 16'd0) ? 16'd1 : rd_entry.duration;
  assign gt      = elapsed > {1'b0, dur};
  assign diff    = elapsed - {1'b0, dur};
  assign idx_inc = {1'b0, cur_idx} + 5'd1;
  assign at_end  = idx_inc >= eff_cnt;

  assign load_dur = (req.entry_duration == 16'd0) ? 16'd1 : req.entry_duration;

  // The result is committed once the output register is free.
  assign resp_load = (state == ST_RESP) && (!out_valid || rsp.ready);

  assign mem_wr.we            = in_fire && (req.req_type == REQ_LOAD);
  assign mem_wr.addr          = req.entry_index;
  assign mem_wr.data.duration = load_dur;
  assign mem_wr.data.frame_id = req.entry_frame_id;
  assign mem_wr.data.flip_x   = req.entry_flip_x;
  assign mem_wr.data.flip_y   = req.entry_flip_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      running   <= 1'b0;
      paused    <= 1'b0;
      tick_act  <= 1'b0;
      elapsed   <= 17'd0;
      cur_idx   <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (resp_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            tick_act <= tick_go;
            state    <= ST_WAIT;
            unique case (req.req_type)
              REQ_TICK: begin
                if (tick_go) begin
                  elapsed <= elapsed + {1'b0, req.time_step};
                end
              end
              REQ_START: begin
                running <= 1'b1;
                paused  <= 1'b0;
              end
              REQ_PAUSE: begin
                if (running) begin
                  paused <= 1'b1;
                end
              end
              REQ_UNPAUSE: paused <= 1'b0;
              REQ_STOP, REQ_LOAD: begin
                running <= 1'b0;
                paused  <= 1'b0;
                elapsed <= 17'd0;
                cur_idx <= 4'd0;
              end
              default: ;
            endcase
          end
        end
        // The entry at the current index is read during this cycle.
        ST_WAIT: state <= tick_act ? ST_CMP : ST_RESP;
        ST_CMP: begin
          if (gt) begin
            state <= ST_WAIT;
            if (at_end && !cfg.repeat_mode) begin
              running  <= 1'b0;
              paused   <= 1'b0;
              elapsed  <= 17'd0;
              tick_act <= 1'b0;
              cur_idx  <= 4'(eff_cnt - 5'd1);
            end else begin
              elapsed <= diff;
              cur_idx <= at_end ? 4'd0 : idx_inc[3:0];
            end
          end else begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (resp_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload; loaded as the result is committed.
  always_ff @(posedge clk) begin
    if (resp_load) begin
      rsp.frame_position <= cur_idx;
      rsp.frame_id       <= (eff_cnt == 5'd0) ? 8'd0 : rd_entry.frame_id;
      rsp.flip_x         <= (eff_cnt != 5'd0) && rd_entry.flip_x;
      rsp.flip_y         <= (eff_cnt != 5'd0) && rd_entry.flip_y;
      rsp.is_running     <= running;
      rsp.is_paused      <= paused;
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/sprite_frame_sequencer_core.sv =====
// Sprite frame sequencer: steps an animation through a table of up to 16 frames.
// Requests arrive as words on the req channel (valid/ready); every accepted word
// gives exactly one result word on the rsp channel with the current frame
// position, its id and mirror flags, and the running and paused flags.
// Table entries are written by load requests; frame count and repeat mode are
// set through the APB port (frame_count at 0x0, repeat_mode at 0x4).
// Steps: an accepted word moves the block to a wait state in which the frame
// memory is read at the current position; any request other than a live tick
// (one that finds the block running, unpaused and with more than one frame)
// then goes straight to the result state. A live tick runs the shared compare
// and subtract on the entry read, and for each frame it passes reads the next
// entry and compares again. The block accepts no new word until the previous
// result has been written into the output register.
// If the receiver stalls, the result waits in the output register; the block
// takes one further request meanwhile and holds its result until the register
// is free. Reset clears the run state, the elapsed time and the position, sets
// repeat_mode to 1 and frame_count to 0; table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sprite_frame_sequencer_core import spr_seq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  spr_seq_req_if.sink      req,
  spr_seq_rsp_if.source    rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  mem_wr_t    mem_wr;
  logic [3:0] cur_idx;
  entry_t     rd_entry;

  // Configuration registers behind the APB port.
  spr_seq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Frame table, read continuously at the current position.
  spr_seq_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (cur_idx),
    .rdata (rd_entry)
  );

  // Sequencer with the shared compare and subtract unit.
  spr_seq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req      (req),
    .rsp      (rsp),
    .mem_wr   (mem_wr),
    .cur_idx  (cur_idx),
    .rd_entry (rd_entry)
  );

  // The block is not ready in the cycle after it takes a word.
  `ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")

  // Pausing is only possible while running.
  `ASSERT_IMP(a_paused_running, rsp.valid, !rsp.is_paused || rsp.is_running, "paused while stopped")

  // A new result is only produced while a request is being worked on.
  `ASSERT_IMP(a_result_when_busy, $rose(rsp.valid), !$past(req.ready), "result from idle")

endmodule

`default_nettype wire

// ===== tb/frame_seq_check_pkg.sv =====
`timescale 1ns / 1ps

package frame_seq_check_pkg;
  import spr_seq_pkg::*;

  // Request codes that the block must accept and leave without effect.
  localparam logic [2:0] REQ_RESERVED_6 = 3'd6;
  localparam logic [2:0] REQ_RESERVED_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] time_step;
    logic [3:0]  slot;
    logic [15:0] duration;
    logic [7:0]  frame_id;
    logic        flip_x;
    logic        flip_y;
  } request_t;

  typedef struct packed {
    logic [3:0] position;
    logic [7:0] frame_id;
    logic       flip_x;
    logic       flip_y;
    logic       running;
    logic       paused;
  } status_t;

  // Tracks the animation state of the block and the status words it still owes.
  class anim_status_tracker;
    entry_t      frames[MAX_FRAMES];
    logic [4:0]  frame_count;
    logic        repeat_on;
    logic        running;
    logic        paused;
    logic [16:0] elapsed;
    logic [3:0]  position;
    status_t     pending_status[$];
    int unsigned failures;

    function new();
      frame_count = 5'd0;
      repeat_on = 1'b1;
      failures = 0;
      halt();
    endfunction

    function void halt();
      running = 1'b0;
      paused = 1'b0;
      elapsed = 17'd0;
      position = 4'd0;
    endfunction

    function void apply_register(logic [0:0] index, logic [31:0] value);
      if (index == REG_FRAME_COUNT) begin
        frame_count = value[4:0];
      end else begin
        repeat_on = value[0];
      end
    endfunction

    function int unsigned active_frames();
      return (frame_count > MAX_FRAMES) ? MAX_FRAMES : frame_count;
    endfunction

    function logic [16:0] span_of(logic [3:0] idx);
      return (frames[idx].duration == 16'd0) ? 17'd1 : {1'b0, frames[idx].duration};
    endfunction

    // Adds the step to the accumulator and walks forward one frame per
    // duration that the accumulator strictly exceeds.
    function void advance_animation(logic [15:0] step);
      int unsigned n;
      int unsigned next_idx;
      logic [16:0] span;
      n = active_frames();
      if (!running || paused || n <= 1) return;
      elapsed = elapsed + step;
      span = span_of(position);
      while (elapsed > span) begin
        elapsed = elapsed - span;
        next_idx = position + 1;
        if (next_idx >= n) begin
          if (!repeat_on) begin
            halt();
            position = 4'(n - 1);
            return;
          end
          next_idx = 0;
        end
        position = 4'(next_idx);
        span = span_of(position);
      end
    endfunction

    function void note_request(request_t w);
      status_t s;
      case (w.kind)
        REQ_TICK: advance_animation(w.time_step);
        REQ_START: begin
          running = 1'b1;
          paused = 1'b0;
        end
        REQ_PAUSE: begin
          if (running) paused = 1'b1;
        end
        REQ_UNPAUSE: paused = 1'b0;
        REQ_STOP: halt();
        REQ_LOAD: begin
          halt();
          frames[w.slot].duration = (w.duration == 16'd0) ? 16'd1 : w.duration;
          frames[w.slot].frame_id = w.frame_id;
          frames[w.slot].flip_x = w.flip_x;
          frames[w.slot].flip_y = w.flip_y;
        end
        default: ;
      endcase
      s.position = position;
      if (active_frames() == 0) begin
        s.frame_id = 8'd0;
        s.flip_x = 1'b0;
        s.flip_y = 1'b0;
      end else begin
        s.frame_id = frames[position].frame_id;
        s.flip_x = frames[position].flip_x;
        s.flip_y = frames[position].flip_y;
      end
      s.running = running;
      s.paused = paused;
      pending_status.push_back(s);
    endfunction

    function void compare_field(string label, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, seen);
        failures++;
      end
    endfunction

    function void check_status(status_t seen);
      status_t want;
      if (pending_status.size() == 0) begin
        $display("%0t: status word with nothing outstanding, expected none, actual %0h",
                 $time, seen);
        failures++;
        return;
      end
      want = pending_status.pop_front();
      compare_field("frame_position", want.position, seen.position);
      compare_field("frame_id", want.frame_id, seen.frame_id);
      compare_field("flip_x", want.flip_x, seen.flip_x);
      compare_field("flip_y", want.flip_y, seen.flip_y);
      compare_field("is_running", want.running, seen.running);
      compare_field("is_paused", want.paused, seen.paused);
    endfunction

    function int unsigned outstanding();
      return pending_status.size();
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Block-level bench for the sprite frame sequencer. Request words are driven
// on the request channel, every accepted word is fed to a tracker that keeps
// its own copy of the animation state, and every status word that leaves the
// block is compared field by field with the oldest one the tracker predicted.
module tb_top;
  import spr_seq_pkg::*;
  import frame_seq_check_pkg::*;

  // This limit only trips when the block has hung.
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int RANDOM_WORDS    = 1650;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES     = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  spr_seq_req_if req_ch ();
  spr_seq_rsp_if rsp_ch ();

  sprite_frame_sequencer_core u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  anim_status_tracker tracker;

  // Stimulus-side bookkeeping. The generator keeps its own note of the frame
  // durations so that it can size tick steps: a tick passes at most one frame
  // plus one per shortest duration contained in its step, and capping the
  // step at four shortest durations keeps every tick to a handful of frames.
  int unsigned words_sent;
  logic [2:0]  last_kind;
  logic [16:0] slot_span[MAX_FRAMES];
  logic [16:0] shortest_span;
  int unsigned span_profile;

  // Receiver control. The sender asks for a long hold-off by bumping
  // hold_off_asks; the receiver counts the stall out in its own process.
  logic        free_flow;
  int unsigned hold_off_asks;
  int unsigned hold_off_served = 0;
  int          stall_left = 0;
  int unsigned cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic request_t make_request(logic [2:0] kind, logic [15:0] step,
                                            logic [3:0] slot, logic [15:0] duration,
                                            logic [7:0] frame_id, logic flip_x,
                                            logic flip_y);
    request_t w;
    w.kind = kind;
    w.time_step = step;
    w.slot = slot;
    w.duration = duration;
    w.frame_id = frame_id;
    w.flip_x = flip_x;
    w.flip_y = flip_y;
    return w;
  endfunction

  // Durations follow the profile of the current phase: short frames, anything
  // at all, or long frames that let full-range tick steps through cheaply.
  // A zero duration slips in now and then and must behave as one.
  function automatic logic [15:0] pick_duration();
    if ($urandom_range(0, 99) < 3) return 16'd0;
    case (span_profile)
      0: return 16'($urandom_range(1, 32));
      1: return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(32768, 65535));
    endcase
  endfunction

  // Mostly ticks on a running animation. After a stop or a load the block is
  // idle, so a start usually follows to keep the ticks doing real work.
  function automatic request_t random_request();
    request_t w;
    int unsigned roll;
    logic [16:0] cap;
    w = make_request(REQ_TICK, 16'($urandom), 4'($urandom), 16'($urandom),
                     8'($urandom), 1'($urandom), 1'($urandom));
    roll = $urandom_range(0, 99);
    if ((last_kind == REQ_STOP || last_kind == REQ_LOAD) && roll < 75) begin
      w.kind = REQ_START;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 58) w.kind = REQ_TICK;
      else if (roll < 68) w.kind = REQ_START;
      else if (roll < 74) w.kind = REQ_PAUSE;
      else if (roll < 80) w.kind = REQ_UNPAUSE;
      else if (roll < 85) w.kind = REQ_STOP;
      else if (roll < 97) w.kind = REQ_LOAD;
      else w.kind = ($urandom_range(0, 1) == 0) ? REQ_RESERVED_6 : REQ_RESERVED_7;
    end
    if (w.kind == REQ_TICK) begin
      if (shortest_span >= 17'd16384) cap = 17'd65535;
      else cap = shortest_span << 2;
      if ($urandom_range(0, 99) < 15) w.time_step = 16'($urandom_range(0, 3));
      else w.time_step = 16'($urandom_range(0, cap));
    end
    if (w.kind == REQ_LOAD) w.duration = pick_duration();
    return w;
  endfunction

  // Offers one request word and returns at the edge that accepts it, then
  // sometimes leaves a gap before the next word.
  task automatic issue(input request_t w);
    if (w.kind == REQ_LOAD) begin
      slot_span[w.slot] = (w.duration == 16'd0) ? 17'd1 : {1'b0, w.duration};
      shortest_span = 17'h1FFFF;
      foreach (slot_span[i]) begin
        if (slot_span[i] < shortest_span) shortest_span = slot_span[i];
      end
    end
    last_kind = w.kind;
    words_sent++;
    req_ch.valid <= 1'b1;
    req_ch.req_type <= w.kind;
    req_ch.time_step <= w.time_step;
    req_ch.entry_index <= w.slot;
    req_ch.entry_duration <= w.duration;
    req_ch.entry_frame_id <= w.frame_id;
    req_ch.entry_flip_x <= w.flip_x;
    req_ch.entry_flip_y <= w.flip_y;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (!free_flow && $urandom_range(0, 1) == 0) begin
      req_ch.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Stops offering words until every predicted status word has come back.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // One APB write: a setup cycle, then the access cycle that completes when
  // pready is seen. psel is left high so that a second write can follow at once.
  task automatic write_register(input logic [0:0] index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.apply_register(index, value);
  endtask

  // Registers are only touched while the block has nothing in flight. The
  // upper bits of each data word are noise that the block must ignore.
  task automatic configure(input logic [4:0] count, input logic wrap);
    wait_idle();
    write_register(REG_FRAME_COUNT, {$urandom} & 32'hFFFF_FFE0 | {27'd0, count});
    write_register(REG_REPEAT_MODE, {$urandom} & 32'hFFFF_FFFE | {31'd0, wrap});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Accepted words on both channels are picked up here at the clock edge.
  // A status word can never belong to a request accepted at the same edge,
  // so noting the request first is always safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        tracker.note_request(make_request(req_ch.req_type, req_ch.time_step,
                                          req_ch.entry_index, req_ch.entry_duration,
                                          req_ch.entry_frame_id, req_ch.entry_flip_x,
                                          req_ch.entry_flip_y));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        tracker.check_status('{position: rsp_ch.frame_position,
                               frame_id: rsp_ch.frame_id,
                               flip_x:   rsp_ch.flip_x,
                               flip_y:   rsp_ch.flip_y,
                               running:  rsp_ch.is_running,
                               paused:   rsp_ch.is_paused});
      end
    end
  end

  // Receiver: a stall in progress runs out first, then a pending hold-off request wins;
  // otherwise ready is high most of the time with random stalls, and without them in free-flowing phases.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_off_served != hold_off_asks) begin
      hold_off_served <= hold_off_asks;
      stall_left <= HOLD_OFF_CYCLES - 1;
      rsp_ch.ready <= 1'b0;
    end else if (free_flow || $urandom_range(0, 3) != 0) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      stall_left <= pick_gap() - 1;
      rsp_ch.ready <= 1'b0;
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned target;
    int unsigned phase;
    int unsigned phase_words;
    int unsigned count_choice;
    logic [15:0] span;
    logic [7:0]  id;

    tracker = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.time_step = 16'd0;
    req_ch.entry_index = 4'd0;
    req_ch.entry_duration = 16'd0;
    req_ch.entry_frame_id = 8'd0;
    req_ch.entry_flip_x = 1'b0;
    req_ch.entry_flip_y = 1'b0;
    free_flow = 1'b0;
    hold_off_asks = 0;
    words_sent = 0;
    last_kind = REQ_TICK;
    span_profile = 0;
    shortest_span = 17'd1;
    foreach (slot_span[i]) slot_span[i] = 17'd1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. With no frames configured a full-size tick does nothing,
    // and a reserved request code just reports the status.
    issue(make_request(REQ_TICK, 16'hFFFF, 4'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    issue(make_request(REQ_RESERVED_6, 16'd0, 4'd0, 16'd0, 8'd0, 1'b0, 1'b0));

    // Fill the whole table before any entry can be read. Slot 0 is loaded
    // with a zero duration, which must act as one; slot 15 gets the longest.
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (i == 0) span = 16'd0;
      else if (i == 1) span = 16'd1;
      else if (i == MAX_FRAMES - 1) span = 16'hFFFF;
      else span = 16'(100 * (i + 1));
      if (i == 0) id = 8'hFF;
      else if (i == MAX_FRAMES - 1) id = 8'h00;
      else id = 8'(i * 17);
      issue(make_request(REQ_LOAD, 16'd0, 4'(i), span, id, ~i[0], i[1]));
    end

    // An oversized frame count behaves as sixteen. One full-size tick walks
    // from frame 0 to the long last frame, where it comes to rest.
    configure(5'd31, 1'b1);
    issue(make_request(REQ_START, 16'd0, 4'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    issue(make_request(REQ_TICK, 16'hFFFF, 4'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    issue(make_request(REQ_PAUSE, 16'd0, 4'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    issue(make_request(REQ_TICK, 16'd1, 4'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    issue(make_request(REQ_UNPAUSE, 16'd0, 4'd0, 16'd0, 8'd0, 1'b0, 1'b0));

    // Lowering the count leaves the position beyond the end: passing that
    // frame counts as passing the last one and wraps to the start.
    configure(5'd3, 1'b1);
    issue(make_request(REQ_TICK, 16'hFFFF, 4'd0, 16'd0, 8'd0, 1'b0, 1'b0));

    // Without repeat the animation halts on its last frame, after which a
    // pause has nothing to pause.
    configure(5'd3, 1'b0);
    issue(make_request(REQ_TICK, 16'hFFFF, 4'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    issue(make_request(REQ_PAUSE, 16'd0, 4'd0, 16'd0, 8'd0, 1'b0, 1'b0));

    // Random part, in phases. Each phase drains the block, picks a new
    // setting (the extremes among them), sometimes reloads the whole table
    // and then sends a burst of mostly well-formed traffic. One phase holds
    // the receiver off for a long stretch while the sender keeps going, and
    // every fourth phase runs without idling on either side.
    target = words_sent + RANDOM_WORDS;
    phase = 0;
    while (words_sent < target) begin
      case ($urandom_range(0, 9))
        0: count_choice = 0;
        1: count_choice = 1;
        2: count_choice = MAX_FRAMES;
        3: count_choice = 31;
        4: count_choice = $urandom_range(MAX_FRAMES + 1, 30);
        default: count_choice = $urandom_range(2, MAX_FRAMES - 1);
      endcase
      configure(5'(count_choice), 1'($urandom));
      free_flow <= (phase % 4 == 1) || (phase == 2);
      if (phase == 2) hold_off_asks <= hold_off_asks + 1;
      span_profile = $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) begin
        for (int s = 0; s < MAX_FRAMES; s++) begin
          issue(make_request(REQ_LOAD, 16'($urandom), 4'(s), pick_duration(),
                             8'($urandom), 1'($urandom), 1'($urandom)));
        end
      end
      phase_words = $urandom_range(60, 100);
      repeat (phase_words) issue(random_request());
      phase++;
    end

    // Let the last status words drain, then give the block a little longer
    // in case it produces anything unasked for.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.outstanding() != 0) begin
      $display("%0t: status words missing, expected %0d more, actual 0",
               $time, tracker.outstanding());
      tracker.failures++;
    end
    if (tracker.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
